// ===== sv/mrp_pkg.sv =====
// Shared types and constants for the Miller-Rabin prime test unit.
// Witness ladder tables, controller states and command/status types.
package mrp_pkg;

    localparam int LadderSteps = 10;
    localparam int PrimeCount  = 12;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLASS, ST_SPLIT, ST_WSEL, ST_PSTEP, ST_PMA, ST_PBB,
        ST_PMB, ST_XCHK, ST_SQM, ST_SQCHK, ST_DONE
    } mrp_state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_SHIFT, CMD_PINIT, CMD_MUL_AB, CMD_MUL_BB,
        CMD_SQ, CMD_NEXTW
    } mrp_cmd_t;

    typedef struct packed {
        logic below_two;
        logic two_three;
        logic even;
        logic d_odd;
        logic e_zero;
        logic e_lsb;
        logic mul_done;
        logic x_one;
        logic x_nm1;
        logic wskip;
        logic wlast;
        logic sq_last;
    } mrp_status_t;

    function automatic logic [63:0] ladder_bound(input logic [3:0] s);
        case (s)
            4'd0:    ladder_bound = 64'd2047;
            4'd1:    ladder_bound = 64'd1373653;
            4'd2:    ladder_bound = 64'd9080191;
            4'd3:    ladder_bound = 64'd25326001;
            4'd4:    ladder_bound = 64'd3215031751;
            4'd5:    ladder_bound = 64'd4759123141;
            4'd6:    ladder_bound = 64'd1122004669633;
            4'd7:    ladder_bound = 64'd2152302898747;
            4'd8:    ladder_bound = 64'd3474749660383;
            4'd9:    ladder_bound = 64'd341550071728321;
            default: ladder_bound = 64'd0;
        endcase
    endfunction

    // zero means the plain first-primes list
    function automatic logic [3:0] ladder_count(input logic [3:0] s);
        case (s)
            4'd0:    ladder_count = 4'd1;
            4'd1:    ladder_count = 4'd2;
            4'd2:    ladder_count = 4'd2;
            4'd3:    ladder_count = 4'd3;
            4'd4:    ladder_count = 4'd4;
            4'd5:    ladder_count = 4'd3;
            4'd6:    ladder_count = 4'd4;
            4'd7:    ladder_count = 4'd5;
            4'd8:    ladder_count = 4'd6;
            4'd9:    ladder_count = 4'd7;
            default: ladder_count = 4'd0;
        endcase
    endfunction

    function automatic logic [63:0] first_prime(input logic [3:0] i);
        case (i)
            4'd0:    first_prime = 64'd2;
            4'd1:    first_prime = 64'd3;
            4'd2:    first_prime = 64'd5;
            4'd3:    first_prime = 64'd7;
            4'd4:    first_prime = 64'd11;
            4'd5:    first_prime = 64'd13;
            4'd6:    first_prime = 64'd17;
            4'd7:    first_prime = 64'd19;
            4'd8:    first_prime = 64'd23;
            4'd9:    first_prime = 64'd29;
            4'd10:   first_prime = 64'd31;
            4'd11:   first_prime = 64'd37;
            default: first_prime = 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] witness(input logic [3:0] s, input logic [3:0] i);
        witness = first_prime(i);
        case (s)
            4'd2:
            begin
                witness = (i == 4'd0) ? 64'd31 : 64'd73;
            end
            4'd5:
            begin
                case (i)
                    4'd0:    witness = 64'd2;
                    4'd1:    witness = 64'd7;
                    default: witness = 64'd61;
                endcase
            end
            4'd6:
            begin
                case (i)
                    4'd0:    witness = 64'd2;
                    4'd1:    witness = 64'd13;
                    4'd2:    witness = 64'd23;
                    default: witness = 64'd1662803;
                endcase
            end
            default: witness = first_prime(i);
        endcase
    endfunction

endpackage

// ===== sv/mrp_ctrl.sv =====
// Controller state machine for the Miller-Rabin prime test unit.
// Depends on mrp_pkg; drives commands into mrp_dp and owns the output register.
module mrp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                stall_in,
    output logic                valid_out,
    input  logic                stall_out,
    input  mrp_pkg::mrp_status_t st,
    output mrp_pkg::mrp_cmd_t   cmd,
    output logic                is_prime
);
    import mrp_pkg::*;

    mrp_state_t state_reg, state_next;
    logic       verdict_reg, verdict_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        cmd          = CMD_NONE;
        stall_in     = 1'b1;
        valid_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                stall_in = 1'b0;
                if (valid_in)
                begin
                    cmd        = CMD_LOAD;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (st.below_two || st.two_three || st.even)
                begin
                    verdict_next = st.two_three;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (st.d_odd)
                    state_next = ST_WSEL;
                else
                    cmd = CMD_SHIFT;
            end
            ST_WSEL:
            begin
                if (st.wlast)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (st.wskip)
                begin
                    cmd = CMD_NEXTW;
                end
                else
                begin
                    cmd        = CMD_PINIT;
                    state_next = ST_PSTEP;
                end
            end
            ST_PSTEP:
            begin
                if (st.e_zero)
                begin
                    state_next = ST_XCHK;
                end
                else if (st.e_lsb)
                begin
                    cmd        = CMD_MUL_AB;
                    state_next = ST_PMA;
                end
                else
                begin
                    cmd        = CMD_MUL_BB;
                    state_next = ST_PMB;
                end
            end
            ST_PMA:
            begin
                if (st.mul_done)
                    state_next = ST_PBB;
            end
            ST_PBB:
            begin
                cmd        = CMD_MUL_BB;
                state_next = ST_PMB;
            end
            ST_PMB:
            begin
                if (st.mul_done)
                    state_next = ST_PSTEP;
            end
            ST_XCHK:
            begin
                if (st.x_one || st.x_nm1)
                begin
                    cmd        = CMD_NEXTW;
                    state_next = ST_WSEL;
                end
                else if (st.sq_last)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd        = CMD_SQ;
                    state_next = ST_SQM;
                end
            end
            ST_SQM:
            begin
                if (st.mul_done)
                    state_next = ST_SQCHK;
            end
            ST_SQCHK:
            begin
                if (st.x_nm1)
                begin
                    cmd        = CMD_NEXTW;
                    state_next = ST_WSEL;
                end
                else if (st.sq_last)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd        = CMD_SQ;
                    state_next = ST_SQM;
                end
            end
            ST_DONE:
            begin
                valid_out = 1'b1;
                if (!stall_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign is_prime = verdict_reg;

endmodule

// ===== sv/mrp_dp.sv =====
// Datapath for the Miller-Rabin prime test unit: operand registers,
// witness selection and a bit-serial modular multiplier. Depends on mrp_pkg.
module mrp_dp #(
    parameter int WORD_WIDTH    = 64,
    parameter int MAX_WITNESSES = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [63:0]             candidate,
    input  mrp_pkg::mrp_cmd_t       cmd,
    output mrp_pkg::mrp_status_t    st
);
    import mrp_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int RW = $clog2(W + 1);
    localparam int CW = $clog2(W + 1);
    localparam logic [3:0] MaxW = 4'((MAX_WITNESSES > PrimeCount) ? PrimeCount :
                                     ((MAX_WITNESSES < 1) ? 1 : MAX_WITNESSES));

    logic [W-1:0]  n_reg, d_reg, acc_reg, base_reg, e_reg;
    logic [RW-1:0] r_reg, i_reg;
    logic [3:0]    step_reg, widx_reg;
    logic [W-1:0]  mx_reg, my_reg, macc_reg;
    logic [CW-1:0] mcnt_reg;
    logic          mbusy_reg, mdest_reg;

    logic [W-1:0]  n_in;
    logic [3:0]    step_in;
    logic [63:0]   wit;
    logic [3:0]    wcount;
    logic [W:0]    t1, t1r, t2, t2r;
    logic          mlast;

    assign n_in = candidate[W-1:0];

    always_comb
    begin
        step_in = 4'(LadderSteps);
        for (int s = LadderSteps - 1; s >= 0; s--)
        begin
            if (64'(n_in) < ladder_bound(4'(s)))
                step_in = 4'(s);
        end
    end

    assign wit    = witness(step_reg, widx_reg);
    assign wcount = (ladder_count(step_reg) == 4'd0) ? MaxW : ladder_count(step_reg);

    assign t1  = {macc_reg, 1'b0};
    assign t1r = (t1 >= {1'b0, n_reg}) ? (t1 - {1'b0, n_reg}) : t1;
    assign t2  = my_reg[W-1] ? (t1r + {1'b0, mx_reg}) : t1r;
    assign t2r = (t2 >= {1'b0, n_reg}) ? (t2 - {1'b0, n_reg}) : t2;
    assign mlast = mbusy_reg && (mcnt_reg == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_MUL_AB || cmd == CMD_MUL_BB || cmd == CMD_SQ)
                mbusy_reg <= 1'b1;
            else if (mlast)
                mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mbusy_reg)
        begin
            macc_reg <= t2r[W-1:0];
            my_reg   <= my_reg << 1;
            mcnt_reg <= mcnt_reg - CW'(1);
            if (mlast)
            begin
                if (mdest_reg)
                    base_reg <= t2r[W-1:0];
                else
                    acc_reg <= t2r[W-1:0];
            end
        end
        case (cmd)
            CMD_LOAD:
            begin
                n_reg    <= n_in;
                d_reg    <= n_in - W'(1);
                r_reg    <= '0;
                step_reg <= step_in;
                widx_reg <= '0;
            end
            CMD_SHIFT:
            begin
                d_reg <= d_reg >> 1;
                r_reg <= r_reg + RW'(1);
            end
            CMD_PINIT:
            begin
                acc_reg  <= W'(1);
                base_reg <= wit[W-1:0];
                e_reg    <= d_reg;
                i_reg    <= RW'(1);
            end
            CMD_MUL_AB:
            begin
                mx_reg    <= acc_reg;
                my_reg    <= base_reg;
                macc_reg  <= '0;
                mcnt_reg  <= CW'(W);
                mdest_reg <= 1'b0;
            end
            CMD_MUL_BB:
            begin
                mx_reg    <= base_reg;
                my_reg    <= base_reg;
                macc_reg  <= '0;
                mcnt_reg  <= CW'(W);
                mdest_reg <= 1'b1;
                e_reg     <= e_reg >> 1;
            end
            CMD_SQ:
            begin
                mx_reg    <= acc_reg;
                my_reg    <= acc_reg;
                macc_reg  <= '0;
                mcnt_reg  <= CW'(W);
                mdest_reg <= 1'b0;
                i_reg     <= i_reg + RW'(1);
            end
            CMD_NEXTW:
            begin
                widx_reg <= widx_reg + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.below_two = (n_reg < W'(2));
        st.two_three = (n_reg == W'(2)) || (n_reg == W'(3));
        st.even      = !n_reg[0];
        st.d_odd     = d_reg[0];
        st.e_zero    = (e_reg == '0);
        st.e_lsb     = e_reg[0];
        st.mul_done  = mlast;
        st.x_one     = (acc_reg == W'(1));
        st.x_nm1     = (acc_reg == (n_reg - W'(1)));
        st.wskip     = (wit >= 64'(n_reg));
        st.wlast     = (widx_reg >= wcount);
        st.sq_last   = (i_reg >= r_reg);
    end

endmodule

// ===== sv/miller_rabin_prime_test_unit.sv =====
// Top level of the Miller-Rabin prime test unit.
// Depends on mrp_pkg, mrp_ctrl and mrp_dp.
//
// Usage:
//   Input channel: candidate with valid_in/stall_in. One transfer starts a test.
//   Output channel: is_prime with valid_out/stall_out, one result per candidate.
//   Candidate bits above WORD_WIDTH are ignored.
// Sequencing:
//   One candidate at a time. Trivial cases (below two, two, three, even) are
//   decided in the classify state without the multiplier. Otherwise n-1 is
//   first split into d * 2^r by shifting, then per witness up to 2*WORD_WIDTH
//   modular multiplications for the exponentiation and r-1 squarings follow.
//   The bit-serial multiplier (one multiplier bit per cycle) dominates the run time.
// Reset: returns to idle, no result pending.
// Stall: the result holds on is_prime with valid_out high until transferred;
//   no new candidate is taken until then.
module miller_rabin_prime_test_unit #(
    parameter int WORD_WIDTH    = 64,
    parameter int MAX_WITNESSES = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [63:0] candidate,
    output logic        valid_out,
    input  logic        stall_out,
    output logic        is_prime
);
    import mrp_pkg::*;

    mrp_cmd_t    cmd;
    mrp_status_t st;

    mrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_in),
        .stall_in  (stall_in),
        .valid_out (valid_out),
        .stall_out (stall_out),
        .st        (st),
        .cmd       (cmd),
        .is_prime  (is_prime)
    );

    mrp_dp #(
        .WORD_WIDTH    (WORD_WIDTH),
        .MAX_WITNESSES (MAX_WITNESSES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (candidate),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
